// File: rtl/core/can_frame_message_reassembler_unit_macros.svh
// Assertion helpers for the CAN message reassembler.
`ifndef CAN_FRAME_MESSAGE_REASSEMBLER_UNIT_MACROS_SVH
`define CAN_FRAME_MESSAGE_REASSEMBLER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CFMR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define CFMR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/cfmr_pkg.sv
`timescale 1ns / 1ps

package cfmr_pkg;

   localparam int STORE_DEPTH_DEFAULT = 64;

   localparam int CNT_W  = 7;
   localparam int CSR_W  = 32;
   localparam int IDX_W  = 1;
   localparam int REQ_W  = 96;
   localparam int USER_W = 3;

   localparam logic [31:0]      ID_BASE_RESET   = 32'h1911_F000;
   localparam logic [CNT_W-1:0] EXP_LEN_RESET   = 7'd57;
   localparam logic [CNT_W-1:0] COUNT_MAX       = 7'd127;

   localparam logic [7:0] SEQ_FIRST     = 8'h01;
   localparam logic [7:0] SEQ_APPEND_LO = 8'h02;
   localparam logic [7:0] SEQ_APPEND_HI = 8'h07;
   localparam logic [7:0] SEQ_CLOSE     = 8'hFF;
   localparam logic [7:0] FIRST_MARK    = 8'h3C;
   localparam logic [7:0] PAD_BYTE      = 8'h55;

   typedef enum logic [IDX_W-1:0] {
      CSR_ID_BASE = 1'b0,
      CSR_EXP_LEN = 1'b1
   } csr_index_type;

endpackage

// File: rtl/core/can_frame_message_reassembler_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  tdata                                  tuser / tlast
// req_      in         can_id, data_byte0 .. data_byte7       -
// rsp_      out        msg_byte                               accepted, length_error,
//                                                             byte_valid / last
// csr_      in         id_base (0), expected_length (1)       -
//
// A frame is taken while idle, then its bytes go into the store one per cycle
// through the single write port (2, 7 or 8 bytes), followed by a check state and
// then either a result load or, for a complete message, the byte stream; a dropped
// frame goes straight to the result load.
// A completed message streams byte by byte (store read, then output load).
// Synchronous reset clears the byte count and control; the store is not cleared.
// A stalled rsp_ side holds the block at its current result; req_tready is high
// only when no frame is in work.

module can_frame_message_reassembler_unit
   import cfmr_pkg::*;
#(
   parameter int STORE_DEPTH = STORE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_tvalid,
   output logic              req_tready,
   // can_id[31:0], data_byte0[39:32], data_byte1 .. data_byte7 up to [95:88]
   input  logic [REQ_W-1:0]  req_tdata,

   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // msg_byte[7:0]
   output logic [7:0]        rsp_tdata,
   // accepted[0], length_error[1], byte_valid[2]
   output logic [USER_W-1:0] rsp_tuser,
   output logic              rsp_tlast,

   input  logic              csr_we,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]  csr_wdata
);

`include "can_frame_message_reassembler_unit_macros.svh"

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int IW = (AW > CNT_W) ? AW : CNT_W;
   localparam int XW = IW + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PUT,
      S_CHECK,
      S_RESULT,
      S_RD,
      S_OUT
   } state_type;

   state_type        state_ff;
   logic [31:0]      id_base_ff;
   logic [CNT_W-1:0] expected_length_ff;
   logic [CNT_W-1:0] byte_count_ff;
   logic [7:0]       frame_byte_ff [0:7];
   logic [2:0]       put_idx_ff;
   logic [2:0]       put_end_ff;
   logic             is_close_ff;
   logic [IW-1:0]    rd_idx_ff;
   logic             res_acc_ff;
   logic             res_err_ff;

   logic             rsp_tvalid_ff;
   logic [7:0]       rsp_data_ff;
   logic [USER_W-1:0] rsp_user_ff;
   logic             rsp_last_ff;

   logic [7:0]       store_mem [0:STORE_DEPTH-1];
   logic [7:0]       rd_data_ff;

   logic [31:0]      req_id;
   logic [7:0]       req_seq;
   logic             id_match;
   logic             pad_ok;
   logic             req_fire;
   logic             out_free;
   logic             rsp_load;
   logic [IW-1:0]    cnt_ext;
   logic [XW-1:0]    cnt_x;
   logic [XW-1:0]    rd_next;
   logic             below_depth;
   logic             stream_last;
   logic             mem_we;
   logic             mem_re;

   assign req_id   = req_tdata[31:0];
   assign req_seq  = req_id[7:0];
   assign id_match = (req_id[31:8] == id_base_ff[31:8]);
   assign pad_ok   = (req_tdata[55:48] == PAD_BYTE) && (req_tdata[63:56] == PAD_BYTE) &&
                     (req_tdata[71:64] == PAD_BYTE) && (req_tdata[79:72] == PAD_BYTE) &&
                     (req_tdata[87:80] == PAD_BYTE) && (req_tdata[95:88] == PAD_BYTE);

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   // output register takes a new request result or message byte this cycle
   assign rsp_load   = ((state_ff == S_RESULT) || (state_ff == S_OUT)) && out_free;

   assign cnt_ext     = IW'(byte_count_ff);
   assign cnt_x       = XW'(byte_count_ff);
   assign rd_next     = XW'(rd_idx_ff) + XW'(1);
   assign below_depth = (cnt_x < XW'(STORE_DEPTH));
   // stream ends at the byte count or at the end of the store, whichever is first
   assign stream_last = (rd_next == cnt_x) || (rd_next == XW'(STORE_DEPTH));

   assign mem_we = (state_ff == S_PUT) && below_depth;
   assign mem_re = (state_ff == S_RD);

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // byte store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[cnt_ext[AW-1:0]] <= frame_byte_ff[put_idx_ff];
      end
      if (mem_re) begin
         rd_data_ff <= store_mem[rd_idx_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_base_ff         <= ID_BASE_RESET;
         expected_length_ff <= EXP_LEN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ID_BASE: id_base_ff         <= csr_wdata;
            CSR_EXP_LEN: expected_length_ff <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         byte_count_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_tvalid_ff && rsp_tready && !rsp_load) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  for (int i = 0; i < 8; i++) begin
                     frame_byte_ff[i] <= req_tdata[32 + 8*i +: 8];
                  end
                  res_acc_ff  <= 1'b0;
                  res_err_ff  <= 1'b0;
                  is_close_ff <= 1'b0;
                  put_idx_ff  <= 3'd0;
                  put_end_ff  <= 3'd7;
                  state_ff    <= S_RESULT;
                  if (id_match) begin
                     if (req_seq == SEQ_FIRST) begin
                        if (req_tdata[39:32] == FIRST_MARK) begin
                           byte_count_ff <= '0;
                           put_idx_ff    <= 3'd1;
                           state_ff      <= S_PUT;
                        end
                     end else if (req_seq inside {[SEQ_APPEND_LO:SEQ_APPEND_HI]}) begin
                        state_ff <= S_PUT;
                     end else if (req_seq == SEQ_CLOSE && pad_ok) begin
                        is_close_ff <= 1'b1;
                        put_end_ff  <= 3'd1;
                        state_ff    <= S_PUT;
                     end
                  end
               end
            end
            S_PUT: begin
               if (byte_count_ff != COUNT_MAX) begin
                  byte_count_ff <= byte_count_ff + CNT_W'(1);
               end
               put_idx_ff <= put_idx_ff + 3'd1;
               if (put_idx_ff == put_end_ff) begin
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (!is_close_ff) begin
                  res_acc_ff <= 1'b1;
                  state_ff   <= S_RESULT;
               end else if (byte_count_ff == expected_length_ff) begin
                  rd_idx_ff <= '0;
                  state_ff  <= S_RD;
               end else begin
                  res_err_ff <= 1'b1;
                  state_ff   <= S_RESULT;
               end
            end
            S_RESULT: begin
               if (out_free) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_data_ff   <= 8'd0;
                  rsp_user_ff   <= {1'b0, res_err_ff, res_acc_ff};
                  rsp_last_ff   <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            S_RD: begin
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_data_ff   <= rd_data_ff;
                  rsp_user_ff   <= {1'b1, 1'b0, 1'b1};
                  rsp_last_ff   <= stream_last;
                  if (stream_last) begin
                     state_ff <= S_IDLE;
                  end else begin
                     rd_idx_ff <= rd_next[IW-1:0];
                     state_ff  <= S_RD;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `CFMR_ASSERT_NEXT(a_req_starts_work, clock, reset, req_fire, state_ff != S_IDLE,
      "request accepted but block stayed idle")
   `CFMR_ASSERT_NEXT(a_count_monotonic, clock, reset, state_ff != S_IDLE,
      byte_count_ff >= $past(byte_count_ff), "byte count dropped outside a restart")
   `CFMR_ASSERT_NOW(a_read_in_range, clock, reset, state_ff == S_RD, rd_next <= cnt_x,
      "store read beyond byte count")
   `CFMR_ASSERT_NEXT(a_stream_continues, clock, reset,
      rsp_tvalid && rsp_tready && rsp_tuser[2] && !rsp_tlast,
      rsp_tvalid || state_ff == S_RD || state_ff == S_OUT,
      "message stream ended without last")

endmodule

// File: dv/cfmr_tb_pkg.sv
`timescale 1ns / 1ps

package cfmr_tb_pkg;

   import cfmr_pkg::*;

   localparam logic [31:0] ID_MATCH_MASK = 32'hFFFF_FF00;
   localparam int          MAX_REPORTS   = 10;
   localparam int          STORE_AW      = $clog2(STORE_DEPTH_DEFAULT);

   typedef struct {
      logic [31:0] can_id;
      logic [7:0]  payload [8];
   } can_frame_type;

   typedef struct packed {
      logic       accepted;
      logic       len_err;
      logic       byte_valid;
      logic [7:0] msg_byte;
      logic       last;
   } frame_result_type;

   function automatic logic [REQ_W-1:0] pack_frame(can_frame_type f);
      logic [REQ_W-1:0] w;
      w = '0;
      w[31:0] = f.can_id;
      for (int i = 0; i < 8; i++) w[32 + 8*i +: 8] = f.payload[i];
      return w;
   endfunction

   class reassembly_scoreboard;
      logic [31:0]      id_base;
      logic [CNT_W-1:0] exp_len;
      logic [7:0]       store [STORE_DEPTH_DEFAULT];
      logic [CNT_W-1:0] byte_cnt;
      frame_result_type pending_results [$];
      int mismatches;
      int results_checked;
      int taken_frames;
      int ignored_frames;
      int messages_streamed;
      int length_errors;

      function new();
         id_base  = ID_BASE_RESET;
         exp_len  = EXP_LEN_RESET;
         byte_cnt = '0;
         foreach (store[i]) store[i] = '0;
      endfunction

      function void set_reg(csr_index_type idx, logic [31:0] value);
         if (idx == CSR_ID_BASE) id_base = value;
         else exp_len = value[CNT_W-1:0];
      endfunction

      // bytes past the store are dropped, the count still runs up to its ceiling
      function void store_byte(logic [7:0] b);
         if (byte_cnt < STORE_DEPTH_DEFAULT) store[byte_cnt[STORE_AW-1:0]] = b;
         if (byte_cnt != COUNT_MAX) byte_cnt++;
      endfunction

      function void predict_frame(can_frame_type f);
         logic [7:0]       seq;
         bit               pad_ok;
         int               n;
         frame_result_type r;
         r = '0;
         r.last = 1'b1;
         seq = f.can_id[7:0];
         if ((f.can_id & ID_MATCH_MASK) == (id_base & ID_MATCH_MASK)) begin
            if (seq == SEQ_FIRST) begin
               if (f.payload[0] == FIRST_MARK) begin
                  byte_cnt = '0;
                  for (int i = 1; i < 8; i++) store_byte(f.payload[i]);
                  r.accepted = 1'b1;
               end
            end else if (seq >= SEQ_APPEND_LO && seq <= SEQ_APPEND_HI) begin
               for (int i = 0; i < 8; i++) store_byte(f.payload[i]);
               r.accepted = 1'b1;
            end else if (seq == SEQ_CLOSE) begin
               pad_ok = 1'b1;
               for (int i = 2; i < 8; i++) if (f.payload[i] != PAD_BYTE) pad_ok = 1'b0;
               if (pad_ok) begin
                  store_byte(f.payload[0]);
                  store_byte(f.payload[1]);
                  if (byte_cnt == exp_len) begin
                     // count is at least two here, so the run is never empty
                     n = (byte_cnt > STORE_DEPTH_DEFAULT) ? STORE_DEPTH_DEFAULT : int'(byte_cnt);
                     for (int i = 0; i < n; i++) begin
                        r.accepted   = 1'b1;
                        r.byte_valid = 1'b1;
                        r.msg_byte   = store[i];
                        r.last       = (i == n - 1);
                        pending_results.push_back(r);
                     end
                     messages_streamed++;
                     taken_frames++;
                     return;
                  end
                  r.len_err = 1'b1;
                  length_errors++;
               end
            end
         end
         if (r.accepted || r.len_err) taken_frames++;
         else ignored_frames++;
         pending_results.push_back(r);
      endfunction

      function void log_mismatch(string what, frame_result_type want, frame_result_type got);
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("mismatch %0d (%s): exp acc=%0b err=%0b vld=%0b byte=%02h last=%0b | %s",
                     mismatches, what, want.accepted, want.len_err, want.byte_valid,
                     want.msg_byte, want.last,
                     $sformatf("got acc=%0b err=%0b vld=%0b byte=%02h last=%0b",
                               got.accepted, got.len_err, got.byte_valid, got.msg_byte,
                               got.last));
      endfunction

      function void check_result(frame_result_type got);
         frame_result_type want;
         results_checked++;
         if (pending_results.size() == 0) begin
            log_mismatch("no response pending", '0, got);
            return;
         end
         want = pending_results.pop_front();
         if (got !== want) log_mismatch("field", want, got);
      endfunction
   endclass

endpackage

// File: dv/tb_can_frame_message_reassembler_unit.sv
`timescale 1ns / 1ps

module tb_can_frame_message_reassembler_unit;

   import cfmr_pkg::*;
   import cfmr_tb_pkg::*;

   localparam int ITEM_TARGET    = 480;
   localparam int SETTLE_CYCLES  = 16;
   localparam int DRAIN_CYCLES   = 32;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef enum int {RDY_ALWAYS, RDY_ALTERNATE, RDY_RANDOM, RDY_BURSTY} ready_mode_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [7:0]        rsp_tdata;
   logic [USER_W-1:0] rsp_tuser;
   logic              rsp_tlast;
   logic              csr_we     = 1'b0;
   logic [IDX_W-1:0]  csr_index  = CSR_ID_BASE;
   logic [CSR_W-1:0]  csr_wdata  = '0;

   reassembly_scoreboard sb = new();

   int             burst_left  = 0;
   int             reg_writes  = 0;
   int             stuck_cycles = 0;
   ready_mode_type ready_mode  = RDY_ALWAYS;
   int             mode_left   = 0;
   logic [7:0]     ready_phase = '0;

   can_frame_message_reassembler_unit #(.STORE_DEPTH(STORE_DEPTH_DEFAULT)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // receiver backpressure: the ready mode is redrawn at random when its hold count runs out
   always @(negedge clock) begin
      if (mode_left == 0) begin
         ready_mode <= ready_mode_type'($urandom_range(0, 3));
         mode_left  <= $urandom_range(64, 256);
      end else begin
         mode_left <= mode_left - 1;
      end
      ready_phase <= ready_phase + 8'd1;
      case (ready_mode)
         RDY_ALWAYS:    rsp_tready <= 1'b1;
         RDY_ALTERNATE: rsp_tready <= ready_phase[0];
         RDY_RANDOM:    rsp_tready <= ($urandom_range(0, 3) != 0);
         default:       rsp_tready <= (ready_phase[2:0] < 3'd3);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result('{accepted: rsp_tuser[0], len_err: rsp_tuser[1],
                           byte_valid: rsp_tuser[2], msg_byte: rsp_tdata, last: rsp_tlast});
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles == WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   function automatic can_frame_type frame_for(logic [7:0] seq);
      can_frame_type f;
      f.can_id = {sb.id_base[31:8], seq};
      foreach (f.payload[i]) f.payload[i] = 8'($urandom);
      return f;
   endfunction

   function automatic can_frame_type close_frame();
      can_frame_type f;
      f = frame_for(SEQ_CLOSE);
      for (int i = 2; i < 8; i++) f.payload[i] = PAD_BYTE;
      return f;
   endfunction

   function automatic can_frame_type append_frame();
      return frame_for(8'($urandom_range(SEQ_APPEND_LO, SEQ_APPEND_HI)));
   endfunction

   // frames the block should drop, plus the odd fully random one
   function automatic can_frame_type stray_frame();
      can_frame_type f;
      logic [7:0]    s;
      int            k;
      case ($urandom_range(0, 4))
         0: begin
            f = frame_for(8'($urandom));
            f.can_id[31:8] = f.can_id[31:8] ^ 24'($urandom_range(1, 24'hFF_FFFF));
         end
         1: begin
            s = 8'($urandom);
            if (s >= SEQ_FIRST && s <= SEQ_APPEND_HI) s = s + SEQ_APPEND_HI + 8'd1;
            if (s == SEQ_CLOSE) s = '0;
            f = frame_for(s);
         end
         2: begin
            f = frame_for(SEQ_FIRST);
            if (f.payload[0] == FIRST_MARK) f.payload[0] = ~FIRST_MARK;
         end
         3: begin
            f = close_frame();
            k = $urandom_range(2, 7);
            f.payload[k] = PAD_BYTE ^ 8'($urandom_range(1, 255));
         end
         default: begin
            f = frame_for(8'($urandom));
            f.can_id = $urandom;
         end
      endcase
      return f;
   endfunction

   task automatic send_frame(can_frame_type f);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= pack_frame(f);
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.predict_frame(f);
   endtask

   // wait until every response is back and the block has gone quiet
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.set_reg(idx, value);
      reg_writes++;
   endtask

   // restart, then appends, then closes until the count reaches target
   task automatic send_message(int target);
      can_frame_type f;
      int            remaining;
      f = frame_for(SEQ_FIRST);
      f.payload[0] = FIRST_MARK;
      send_frame(f);
      remaining = target - 7;
      while (remaining >= 10) begin
         if ($urandom_range(0, 9) == 0) send_frame(stray_frame());
         send_frame(append_frame());
         remaining -= 8;
      end
      while (remaining > 0) begin
         send_frame(close_frame());
         remaining -= 2;
      end
   endtask

   initial begin
      can_frame_type f;
      int            phase;
      int            exp_len;
      int            target;
      logic [31:0]   base;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // appends only from reset: closes land on 58, 60, 62 and then 64 bytes
      write_reg(CSR_EXP_LEN, 32'd64);
      for (int k = 0; k < 7; k++) begin
         f = frame_for((k < 6) ? SEQ_APPEND_HI - 8'(k) : SEQ_APPEND_LO);
         if (k == 0) foreach (f.payload[i]) f.payload[i] = 8'h00;
         if (k == 1) foreach (f.payload[i]) f.payload[i] = 8'hFF;
         send_frame(f);
      end
      for (int c = 0; c < 4; c++) begin
         f = close_frame();
         if (c == 3) begin
            f.payload[0] = 8'hFF;
            f.payload[1] = 8'h00;
         end
         send_frame(f);
      end

      // no restart: the count runs past the store, saturates, then matches
      settle();
      write_reg(CSR_EXP_LEN, 32'(COUNT_MAX));
      repeat (8) send_frame(append_frame());
      send_frame(close_frame());

      settle();
      write_reg(CSR_EXP_LEN, 32'(EXP_LEN_RESET));
      f = frame_for(SEQ_FIRST);
      f.payload[0] = FIRST_MARK;
      f.can_id[31] = ~f.can_id[31];
      send_frame(f);
      send_frame(frame_for(SEQ_APPEND_HI + 8'd1));
      f = frame_for(SEQ_FIRST);
      f.payload[0] = FIRST_MARK + 8'd1;
      send_frame(f);
      f = close_frame();
      f.payload[7] = 8'h54;
      send_frame(f);
      f = frame_for(SEQ_FIRST);
      f.payload[0] = FIRST_MARK;
      send_frame(f);

      phase = 0;
      while (sb.taken_frames + sb.ignored_frames < ITEM_TARGET) begin
         settle();
         if (phase < 2 || $urandom_range(0, 2) == 0) begin
            case (phase)
               0:       base = 32'h0000_0000;
               1:       base = 32'hFFFF_FF00;
               default: begin
                  base = $urandom;
                  if (base > 32'hFFFF_FF00) base = 32'hFFFF_FF00;
               end
            endcase
            write_reg(CSR_ID_BASE, base);
         end
         case (phase)
            0:       exp_len = 1;
            1:       exp_len = 9;
            2:       exp_len = 63;
            default: exp_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 64)
                                                          : 2 * $urandom_range(4, 31) + 1;
         endcase
         write_reg(CSR_EXP_LEN, 32'(exp_len));
         repeat ($urandom_range(2, 5)) begin
            if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) send_frame(stray_frame());
            // even or tiny lengths cannot be hit after a restart
            target = (exp_len % 2 == 1 && exp_len >= 9) ? exp_len : 2 * $urandom_range(4, 31) + 1;
            if ($urandom_range(0, 7) == 0) target = 2 * $urandom_range(4, 31) + 1;
            send_message(target);
         end
         phase++;
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d frames (%0d taken, %0d dropped) across %0d register writes.",
               sb.taken_frames + sb.ignored_frames, sb.taken_frames, sb.ignored_frames,
               reg_writes);
      $display("Checked %0d responses: %0d messages streamed, %0d length errors, %0d mismatches.",
               sb.results_checked, sb.messages_streamed, sb.length_errors, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
